@@ src/lkp_pkg.sv @@
package lkp_pkg;

  // entries in the queue between front and back end
  localparam int QUEUE_DEPTH = 2;

  typedef enum logic [2:0] {
    ST_LIG     = 3'd0,
    ST_KERN    = 3'd1,
    ST_NONE    = 3'd2,
    ST_RANGE   = 3'd3,
    ST_WRITTEN = 3'd4
  } status_t;

  typedef enum logic [1:0] {
    CMD_LOOKUP   = 2'd0,
    CMD_WR_GLYPH = 2'd1,
    CMD_WR_STEP  = 2'd2,
    CMD_UNUSED   = 2'd3
  } command_t;

  // what the back end has to do with a queued job
  typedef enum logic [1:0] {
    OP_RESP,
    OP_LOOKUP,
    OP_WR_GLYPH,
    OP_WR_STEP
  } op_t;

  typedef enum logic [1:0] {
    BK_IDLE,
    BK_GLYPH,
    BK_HEAD,
    BK_WALK
  } back_state_t;

  localparam logic [0:0] CFG_GLYPH_COUNT = 1'b0;
  localparam logic [0:0] CFG_EIGHT_BIT   = 1'b1;

  typedef struct packed {
    op_t         op;
    status_t     status;
    logic [13:0] kern;
    logic [13:0] glyph;
    logic [9:0]  index;
    logic [8:0]  g1;
    logic [8:0]  g2;
    logic [19:0] glyph_word;  // program start, has-program, main code
    logic [25:0] step_word;   // stop, next code, kern, goto, value
  } job_t;

endpackage

@@ src/lkp_if.sv @@
interface lkp_item_if;
  logic        valid;
  logic        ready;
  logic [1:0]  command;
  logic [9:0]  table_index;
  logic [8:0]  first_glyph;
  logic [8:0]  second_glyph;
  logic [8:0]  entry_main_code;
  logic        entry_has_program;
  logic [9:0]  entry_program_start;
  logic        entry_stop;
  logic [8:0]  entry_next_code;
  logic        entry_is_kern;
  logic        entry_is_goto;
  logic [13:0] entry_value;

  modport source (
    output valid, command, table_index, first_glyph, second_glyph,
           entry_main_code, entry_has_program, entry_program_start,
           entry_stop, entry_next_code, entry_is_kern, entry_is_goto, entry_value,
    input  ready
  );
  modport sink (
    input  valid, command, table_index, first_glyph, second_glyph,
           entry_main_code, entry_has_program, entry_program_start,
           entry_stop, entry_next_code, entry_is_kern, entry_is_goto, entry_value,
    output ready
  );
endinterface

interface lkp_result_if;
  logic               valid;
  logic               ready;
  logic [2:0]         status;
  logic signed [13:0] kern_value;
  logic [13:0]        result_glyph;

  modport source (output valid, status, kern_value, result_glyph, input ready);
  modport sink (input valid, status, kern_value, result_glyph, output ready);
endinterface

@@ src/lkp_front.sv @@
module lkp_front #(
  parameter int GLYPH_ENTRIES = 512,
  parameter int STEP_ENTRIES  = 1024
) (
  lkp_item_if.sink          item_in,
  input  logic [8:0]        glyph_count,
  output logic              push_valid,
  input  logic              push_ready,
  output lkp_pkg::job_t     push_job
);

  logic [31:0] g1_wide, g2_wide, gc_wide, ti_wide;
  logic        out_of_range;

  assign g1_wide = 32'(item_in.first_glyph);
  assign g2_wide = 32'(item_in.second_glyph);
  assign gc_wide = 32'(glyph_count);
  assign ti_wide = 32'(item_in.table_index);

  assign out_of_range = (g1_wide >= gc_wide) || (g2_wide >= gc_wide) ||
                        (g1_wide >= 32'(GLYPH_ENTRIES)) || (g2_wide >= 32'(GLYPH_ENTRIES));

  assign push_valid    = item_in.valid;
  assign item_in.ready = push_ready;

  always_comb begin
    push_job            = '0;
    push_job.op         = lkp_pkg::OP_RESP;
    push_job.index      = item_in.table_index;
    push_job.g1         = item_in.first_glyph;
    push_job.g2         = item_in.second_glyph;
    push_job.glyph_word = {item_in.entry_program_start, item_in.entry_has_program,
                           item_in.entry_main_code};
    push_job.step_word  = {item_in.entry_stop, item_in.entry_next_code, item_in.entry_is_kern,
                           item_in.entry_is_goto, item_in.entry_value};
    unique case (lkp_pkg::command_t'(item_in.command))
      lkp_pkg::CMD_LOOKUP: begin
        push_job.glyph = 14'(item_in.second_glyph);
        if (out_of_range) begin
          push_job.status = lkp_pkg::ST_RANGE;
        end else begin
          push_job.op = lkp_pkg::OP_LOOKUP;
        end
      end
      lkp_pkg::CMD_WR_GLYPH: begin
        if (ti_wide >= 32'(GLYPH_ENTRIES)) begin
          push_job.status = lkp_pkg::ST_RANGE;
        end else begin
          push_job.op     = lkp_pkg::OP_WR_GLYPH;
          push_job.status = lkp_pkg::ST_WRITTEN;
        end
      end
      lkp_pkg::CMD_WR_STEP: begin
        if (ti_wide >= 32'(STEP_ENTRIES)) begin
          push_job.status = lkp_pkg::ST_RANGE;
        end else begin
          push_job.op     = lkp_pkg::OP_WR_STEP;
          push_job.status = lkp_pkg::ST_WRITTEN;
        end
      end
      lkp_pkg::CMD_UNUSED: begin
        push_job.status = lkp_pkg::ST_NONE;
        push_job.glyph  = 14'(item_in.second_glyph);
      end
    endcase
  end

endmodule

@@ src/lkp_queue.sv @@
module lkp_queue (
  input  logic          clk,
  input  logic          rst,
  input  logic          push_valid,
  output logic          push_ready,
  input  lkp_pkg::job_t push_job,
  output logic          pop_valid,
  input  logic          pop_ready,
  output lkp_pkg::job_t pop_job
);

  localparam int PW = (lkp_pkg::QUEUE_DEPTH > 1) ? $clog2(lkp_pkg::QUEUE_DEPTH) : 1;
  localparam int CW = $clog2(lkp_pkg::QUEUE_DEPTH + 1);

  lkp_pkg::job_t slots [lkp_pkg::QUEUE_DEPTH];
  logic [PW-1:0] wr_ptr, rd_ptr;
  logic [CW-1:0] count;
  logic          push, pop;

  assign push_ready = (32'(count) < 32'(lkp_pkg::QUEUE_DEPTH));
  assign pop_valid  = (count != '0);
  assign push       = push_valid && push_ready;
  assign pop        = pop_valid && pop_ready;
  assign pop_job    = slots[rd_ptr];

  always_ff @(posedge clk) begin
    if (push) begin
      slots[wr_ptr] <= push_job;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) begin
        wr_ptr <= (32'(wr_ptr) == lkp_pkg::QUEUE_DEPTH - 1) ? '0 : wr_ptr + PW'(1);
      end
      if (pop) begin
        rd_ptr <= (32'(rd_ptr) == lkp_pkg::QUEUE_DEPTH - 1) ? '0 : rd_ptr + PW'(1);
      end
      if (push && !pop) begin
        count <= count + CW'(1);
      end else if (pop && !push) begin
        count <= count - CW'(1);
      end
    end
  end

endmodule

@@ src/lkp_back.sv @@
module lkp_back #(
  parameter int GLYPH_ENTRIES = 512,
  parameter int STEP_ENTRIES  = 1024
) (
  input  logic          clk,
  input  logic          rst,
  input  logic          eight_bit_mode,
  input  logic          pop_valid,
  output logic          pop_ready,
  input  lkp_pkg::job_t pop_job,
  lkp_result_if.source  result_out
);

  localparam int GA = (GLYPH_ENTRIES > 1) ? $clog2(GLYPH_ENTRIES) : 1;
  localparam int SA = (STEP_ENTRIES > 1) ? $clog2(STEP_ENTRIES) : 1;
  localparam int IW = $clog2(STEP_ENTRIES + 1);

  logic [19:0] glyph_mem [GLYPH_ENTRIES];
  logic [25:0] step_mem [STEP_ENTRIES];

  lkp_pkg::back_state_t state, state_next;
  logic [19:0]     glyph1_q, glyph2_q;
  logic [25:0]     step_q;
  logic [IW-1:0]   idx;
  logic [13:0]     second;

  logic             res_valid;
  lkp_pkg::status_t res_status;
  logic [13:0]      res_kern, res_glyph;

  // control decoded each cycle
  logic             glyph_rd_en, glyph_we, step_we, step_rd_en, res_load;
  logic [IW-1:0]    step_rd_idx;
  lkp_pkg::status_t res_status_next;
  logic [13:0]      res_kern_next, res_glyph_next;

  logic [31:0] g1_wide, g2_wide, wr_wide, start_wide, target_wide, idx_wide;
  logic        has_program, start_in, target_in, last;
  logic        stop, is_kern, is_goto, hit, head_goto, walk_end;
  logic [8:0]  next_code;
  logic [13:0] value, none_kern;
  logic        out_free, start_ok;

  assign g1_wide     = 32'(pop_job.g1);
  assign g2_wide     = 32'(pop_job.g2);
  assign wr_wide     = 32'(pop_job.index);
  assign has_program = glyph1_q[9];
  assign start_wide  = 32'(glyph1_q[19:10]);
  assign start_in    = start_wide < 32'(STEP_ENTRIES);

  assign stop        = step_q[25];
  assign next_code   = step_q[24:16];
  assign is_kern     = step_q[15];
  assign is_goto     = step_q[14];
  assign value       = step_q[13:0];
  assign target_wide = 32'(value);
  assign target_in   = target_wide < 32'(STEP_ENTRIES);
  assign idx_wide    = 32'(idx);
  assign last        = idx_wide == 32'(STEP_ENTRIES - 1);

  assign hit       = next_code == glyph2_q[8:0];
  // a goto only counts as the program's head step
  assign head_goto = (state == lkp_pkg::BK_HEAD) && is_kern && is_goto;
  assign walk_end  = hit || stop || last;
  assign none_kern = {13'b0, eight_bit_mode};

  assign out_free = !res_valid || result_out.ready;
  assign start_ok = pop_valid && out_free;

  always_comb begin
    state_next = state;
    unique case (state)
      lkp_pkg::BK_IDLE: begin
        if (start_ok && pop_job.op == lkp_pkg::OP_LOOKUP) begin
          state_next = lkp_pkg::BK_GLYPH;
        end
      end
      lkp_pkg::BK_GLYPH: begin
        state_next = (has_program && start_in) ? lkp_pkg::BK_HEAD : lkp_pkg::BK_IDLE;
      end
      lkp_pkg::BK_HEAD, lkp_pkg::BK_WALK: begin
        if (head_goto) begin
          state_next = target_in ? lkp_pkg::BK_WALK : lkp_pkg::BK_IDLE;
        end else begin
          state_next = walk_end ? lkp_pkg::BK_IDLE : lkp_pkg::BK_WALK;
        end
      end
    endcase
  end

  always_comb begin
    pop_ready       = 1'b0;
    glyph_rd_en     = 1'b0;
    glyph_we        = 1'b0;
    step_we         = 1'b0;
    step_rd_en      = 1'b0;
    step_rd_idx     = '0;
    res_load        = 1'b0;
    res_status_next = lkp_pkg::ST_NONE;
    res_kern_next   = none_kern;
    res_glyph_next  = second;
    unique case (state)
      lkp_pkg::BK_IDLE: begin
        pop_ready       = out_free;
        res_status_next = pop_job.status;
        res_kern_next   = pop_job.kern;
        res_glyph_next  = pop_job.glyph;
        if (start_ok) begin
          unique case (pop_job.op)
            lkp_pkg::OP_RESP:     res_load = 1'b1;
            lkp_pkg::OP_WR_GLYPH: begin
              glyph_we = 1'b1;
              res_load = 1'b1;
            end
            lkp_pkg::OP_WR_STEP: begin
              step_we  = 1'b1;
              res_load = 1'b1;
            end
            lkp_pkg::OP_LOOKUP:   glyph_rd_en = 1'b1;
          endcase
        end
      end
      lkp_pkg::BK_GLYPH: begin
        if (has_program && start_in) begin
          step_rd_en  = 1'b1;
          step_rd_idx = start_wide[IW-1:0];
        end else begin
          res_load = 1'b1;
        end
      end
      lkp_pkg::BK_HEAD, lkp_pkg::BK_WALK: begin
        if (head_goto) begin
          if (target_in) begin
            step_rd_en  = 1'b1;
            step_rd_idx = target_wide[IW-1:0];
          end else begin
            res_load = 1'b1;
          end
        end else if (hit) begin
          res_load = 1'b1;
          if (is_kern) begin
            res_status_next = lkp_pkg::ST_KERN;
            res_kern_next   = value;
          end else begin
            res_status_next = lkp_pkg::ST_LIG;
            res_kern_next   = '0;
            res_glyph_next  = value;
          end
        end else if (stop || last) begin
          res_load = 1'b1;
        end else begin
          step_rd_en  = 1'b1;
          step_rd_idx = idx + IW'(1);
        end
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (glyph_we) begin
      glyph_mem[wr_wide[GA-1:0]] <= pop_job.glyph_word;
    end
    if (glyph_rd_en) begin
      glyph1_q <= glyph_mem[g1_wide[GA-1:0]];
      glyph2_q <= glyph_mem[g2_wide[GA-1:0]];
      second   <= pop_job.glyph;
    end
  end

  always_ff @(posedge clk) begin
    if (step_we) begin
      step_mem[wr_wide[SA-1:0]] <= pop_job.step_word;
    end
    if (step_rd_en) begin
      step_q <= step_mem[step_rd_idx[SA-1:0]];
      idx    <= step_rd_idx;
    end
  end

  always_ff @(posedge clk) begin
    if (res_load) begin
      res_status <= res_status_next;
      res_kern   <= res_kern_next;
      res_glyph  <= res_glyph_next;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= lkp_pkg::BK_IDLE;
      res_valid <= 1'b0;
    end else begin
      state <= state_next;
      if (res_load) begin
        res_valid <= 1'b1;
      end else if (result_out.ready) begin
        res_valid <= 1'b0;
      end
    end
  end

  assign result_out.valid        = res_valid;
  assign result_out.status       = res_status;
  assign result_out.kern_value   = $signed(res_kern);
  assign result_out.result_glyph = res_glyph;

endmodule

@@ src/ligature_kern_program_lookup.sv @@
// Ligature/kern program lookup.
// item_in carries commands: a lookup of a glyph pair, or a write of one glyph
// or step table entry. result_out returns exactly one beat per command, in order.
// cfg_wr_en/cfg_index/cfg_data set glyph_count (index 0) and eight_bit_mode
// (index 1); write them only while no command is in flight.
// The front end classifies each beat (range checks, command decode) and
// queues it two deep; the back end owns both tables and the result register.
// Writes, rejected codes and unused commands are answered from the idle state alone and
// can follow one another every cycle while result_out is ready. A lookup holds the back
// end while it reads both glyph entries, then the step entries one at a time (a leading
// goto among them), as the step table has one read port and each step needs the previous
// one's data. Each result passes through the queue and then the registered result output.
// Reset (rst, synchronous) empties the queue, drops any pending result and
// clears both registers to zero; table contents are undefined until written.
// While result_out is stalled the result holds; the back end waits and the
// queue keeps taking beats until full.
module ligature_kern_program_lookup #(
  parameter int GLYPH_ENTRIES = 512,
  parameter int STEP_ENTRIES  = 1024
) (
  input  logic         clk,
  input  logic         rst,
  input  logic         cfg_wr_en,
  input  logic [0:0]   cfg_index,
  input  logic [8:0]   cfg_data,
  lkp_item_if.sink     item_in,
  lkp_result_if.source result_out
);

  logic [8:0]    glyph_count;
  logic          eight_bit_mode;
  logic          push_valid, push_ready, pop_valid, pop_ready;
  lkp_pkg::job_t push_job, pop_job;

  always_ff @(posedge clk) begin
    if (rst) begin
      glyph_count    <= '0;
      eight_bit_mode <= 1'b0;
    end else if (cfg_wr_en) begin
      unique case (cfg_index)
        lkp_pkg::CFG_GLYPH_COUNT: glyph_count    <= cfg_data;
        lkp_pkg::CFG_EIGHT_BIT:   eight_bit_mode <= cfg_data[0];
      endcase
    end
  end

  lkp_front #(
    .GLYPH_ENTRIES (GLYPH_ENTRIES),
    .STEP_ENTRIES  (STEP_ENTRIES)
  ) u_front (
    .item_in     (item_in),
    .glyph_count (glyph_count),
    .push_valid  (push_valid),
    .push_ready  (push_ready),
    .push_job    (push_job)
  );

  lkp_queue u_queue (
    .clk        (clk),
    .rst        (rst),
    .push_valid (push_valid),
    .push_ready (push_ready),
    .push_job   (push_job),
    .pop_valid  (pop_valid),
    .pop_ready  (pop_ready),
    .pop_job    (pop_job)
  );

  lkp_back #(
    .GLYPH_ENTRIES (GLYPH_ENTRIES),
    .STEP_ENTRIES  (STEP_ENTRIES)
  ) u_back (
    .clk            (clk),
    .rst            (rst),
    .eight_bit_mode (eight_bit_mode),
    .pop_valid      (pop_valid),
    .pop_ready      (pop_ready),
    .pop_job        (pop_job),
    .result_out     (result_out)
  );

endmodule

@@ src/lkp_checker.sv @@
module lkp_checker (
  input logic        clk,
  input logic        rst,
  input logic        out_valid,
  input logic        out_ready,
  input logic [2:0]  status,
  input logic [13:0] kern,
  input logic [13:0] glyph
);

  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> out_valid && $stable(status) && $stable(kern) && $stable(glyph))
    else $error("result changed while stalled");

  a_reset_empty: assert property (@(posedge clk) rst |=> !out_valid)
    else $error("result beat straight after reset");

  a_status_legal: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> status <= 3'(lkp_pkg::ST_WRITTEN))
    else $error("undefined status code");

  a_write_zero: assert property (@(posedge clk) disable iff (rst)
    out_valid && status == 3'(lkp_pkg::ST_WRITTEN) |-> kern == '0 && glyph == '0)
    else $error("write answer carries data");

  a_none_kern: assert property (@(posedge clk) disable iff (rst)
    out_valid && (status == 3'(lkp_pkg::ST_NONE) || status == 3'(lkp_pkg::ST_LIG))
    |-> kern == 14'd0 || kern == 14'd1)
    else $error("default kern out of range");

endmodule

bind ligature_kern_program_lookup lkp_checker u_lkp_checker (
  .clk       (clk),
  .rst       (rst),
  .out_valid (result_out.valid),
  .out_ready (result_out.ready),
  .status    (result_out.status),
  .kern      (result_out.kern_value),
  .glyph     (result_out.result_glyph)
);

@@ tb/sv/tb_top.sv @@
`timescale 1ns / 1ps

module tb_top;

  localparam int GLYPH_DEPTH = 512;
  localparam int STEP_DEPTH  = 1024;
  localparam int STUCK_LIMIT = 20000;
  localparam int FAULT_SHOWN = 10;

  typedef struct packed {
    lkp_pkg::command_t command;
    logic [9:0]  table_index;
    logic [8:0]  first_glyph;
    logic [8:0]  second_glyph;
    logic [8:0]  entry_main_code;
    logic        entry_has_program;
    logic [9:0]  entry_program_start;
    logic        entry_stop;
    logic [8:0]  entry_next_code;
    logic        entry_is_kern;
    logic        entry_is_goto;
    logic [13:0] entry_value;
  } cmd_t;

  typedef struct packed {
    lkp_pkg::status_t status;
    logic [13:0] kern;
    logic [13:0] glyph;
  } reply_t;

  typedef struct packed {
    cmd_t   cmd;
    reply_t want;
  } queued_cmd_t;

  logic       clk;
  logic       rst;
  logic       cfg_wr_en;
  logic [0:0] cfg_index;
  logic [8:0] cfg_data;

  lkp_item_if   item_bus();
  lkp_result_if result_bus();

  ligature_kern_program_lookup i_dut (
    .clk       (clk),
    .rst       (rst),
    .cfg_wr_en (cfg_wr_en),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .item_in   (item_bus),
    .result_out(result_bus)
  );

  // shadow of the block's tables and registers
  logic [19:0] glyph_shadow [GLYPH_DEPTH];
  bit          glyph_known  [GLYPH_DEPTH];
  logic [25:0] step_shadow  [STEP_DEPTH];
  bit          step_known   [STEP_DEPTH];
  logic [8:0]  glyph_limit;
  bit          eight_bit;

  queued_cmd_t backlog[$];
  reply_t      replies_due[$];
  logic [8:0]  font_codes[$];
  int          prog_heads[$];
  queued_cmd_t held;

  int in_flight;
  int issued;
  int faults;
  int result_count;
  int stuck_cycles;
  bit beat_taken;
  int src_gap;
  bit src_calm;
  int sink_hold;
  bit sink_calm;

  initial clk = 1'b0;
  always #5 clk = ~clk;

  // Works out the reply to one command and applies any table write.
  // blind is set when a lookup would read an entry never written.
  function automatic reply_t predict_reply(input cmd_t c, output bit blind);
    reply_t      r;
    logic [19:0] ent;
    logic [25:0] st;
    logic [8:0]  code;
    int          idx;
    bit          done;
    blind    = 1'b0;
    done     = 1'b0;
    r.status = lkp_pkg::ST_NONE;
    r.kern   = '0;
    r.glyph  = {5'd0, c.second_glyph};
    case (c.command)
      lkp_pkg::CMD_WR_GLYPH: begin
        r.glyph = '0;
        if (c.table_index >= GLYPH_DEPTH) begin
          r.status = lkp_pkg::ST_RANGE;
        end else begin
          glyph_shadow[c.table_index] =
            {c.entry_program_start, c.entry_has_program, c.entry_main_code};
          glyph_known[c.table_index] = 1'b1;
          r.status = lkp_pkg::ST_WRITTEN;
        end
      end
      lkp_pkg::CMD_WR_STEP: begin
        r.glyph = '0;
        if (c.table_index >= STEP_DEPTH) begin
          r.status = lkp_pkg::ST_RANGE;
        end else begin
          step_shadow[c.table_index] = {c.entry_stop, c.entry_next_code,
            c.entry_is_kern, c.entry_is_goto, c.entry_value};
          step_known[c.table_index] = 1'b1;
          r.status = lkp_pkg::ST_WRITTEN;
        end
      end
      lkp_pkg::CMD_LOOKUP: begin
        if (c.first_glyph >= glyph_limit || c.second_glyph >= glyph_limit) begin
          r.status = lkp_pkg::ST_RANGE;
        end else begin
          r.kern = {13'd0, eight_bit};
          blind  = !glyph_known[c.first_glyph];
          ent    = glyph_shadow[c.first_glyph];
          if (!blind && ent[9]) begin
            idx   = int'(ent[19:10]);
            blind = !step_known[idx] || !glyph_known[c.second_glyph];
            st    = step_shadow[idx];
            // a goto only counts as the program's first step
            if (!blind && st[15] && st[14]) idx = int'(st[13:0]);
            code = glyph_shadow[c.second_glyph][8:0];
            while (!blind && !done && idx < STEP_DEPTH) begin
              st = step_shadow[idx];
              if (!step_known[idx]) begin
                blind = 1'b1;
              end else if (st[24:16] == code) begin
                done = 1'b1;
                if (st[15]) begin
                  r.status = lkp_pkg::ST_KERN;
                  r.kern   = st[13:0];
                end else begin
                  r.status = lkp_pkg::ST_LIG;
                  r.kern   = '0;
                  r.glyph  = st[13:0];
                end
              end else if (st[25]) begin
                done = 1'b1;
              end else begin
                idx++;
              end
            end
          end
        end
      end
      default: ;
    endcase
    return r;
  endfunction

  function automatic bit add_item(input cmd_t c);
    reply_t r;
    bit     blind;
    r = predict_reply(c, blind);
    if (blind) return 1'b0;
    if (c.command == lkp_pkg::CMD_WR_GLYPH && r.status == lkp_pkg::ST_WRITTEN)
      font_codes.push_back(c.table_index[8:0]);
    backlog.push_back('{c, r});
    in_flight++;
    issued++;
    return 1'b1;
  endfunction

  function automatic cmd_t rand_cmd();
    cmd_t c;
    c.command             = lkp_pkg::command_t'($urandom_range(0, 3));
    c.table_index         = 10'($urandom_range(0, 1023));
    c.first_glyph         = 9'($urandom_range(0, 511));
    c.second_glyph        = 9'($urandom_range(0, 511));
    c.entry_main_code     = 9'($urandom_range(0, 511));
    c.entry_has_program   = 1'($urandom_range(0, 1));
    c.entry_program_start = 10'($urandom_range(0, 1023));
    c.entry_stop          = 1'($urandom_range(0, 1));
    c.entry_next_code     = 9'($urandom_range(0, 511));
    c.entry_is_kern       = 1'($urandom_range(0, 1));
    c.entry_is_goto       = 1'($urandom_range(0, 1));
    c.entry_value         = 14'($urandom_range(0, 16383));
    return c;
  endfunction

  function automatic cmd_t glyph_cmd(int at, int main_code, bit has, int start);
    cmd_t c;
    c = rand_cmd();
    c.command             = lkp_pkg::CMD_WR_GLYPH;
    c.table_index         = 10'(at);
    c.entry_main_code     = 9'(main_code);
    c.entry_has_program   = has;
    c.entry_program_start = 10'(start);
    return c;
  endfunction

  function automatic cmd_t step_cmd(int at, bit stop, int next, bit kern, bit hop,
                                    int value);
    cmd_t c;
    c = rand_cmd();
    c.command         = lkp_pkg::CMD_WR_STEP;
    c.table_index     = 10'(at);
    c.entry_stop      = stop;
    c.entry_next_code = 9'(next);
    c.entry_is_kern   = kern;
    c.entry_is_goto   = hop;
    c.entry_value     = 14'(value);
    return c;
  endfunction

  function automatic cmd_t pair_cmd(int g1, int g2);
    cmd_t c;
    c = rand_cmd();
    c.command      = lkp_pkg::CMD_LOOKUP;
    c.first_glyph  = 9'(g1);
    c.second_glyph = 9'(g2);
    return c;
  endfunction

  function automatic cmd_t unused_cmd();
    cmd_t c;
    c = rand_cmd();
    c.command = lkp_pkg::CMD_UNUSED;
    return c;
  endfunction

  // small code pools so that main codes and next codes meet often
  function automatic int pool_code();
    return ($urandom_range(0, 7) == 0) ? $urandom_range(0, 511) : $urandom_range(0, 7);
  endfunction

  function automatic int font_code();
    return ($urandom_range(0, 3) == 0) ? $urandom_range(0, 511) : $urandom_range(0, 47);
  endfunction

  function automatic int pick_glyph();
    if (font_codes.size() > 0 && $urandom_range(0, 9) != 0)
      return int'(font_codes[$urandom_range(0, font_codes.size() - 1)]);
    return $urandom_range(0, 511);
  endfunction

  function automatic int draw_gap(bit calm);
    int r;
    if (calm) return 0;
    r = $urandom_range(0, 99);
    if (r < 55) return 0;
    if (r < 88) return $urandom_range(1, 3);
    return $urandom_range(4, 40);
  endfunction

  task automatic add_program();
    int len;
    int head;
    int k;
    int target;
    bit hop;
    bit kern;
    len = $urandom_range(1, 6);
    if ($urandom_range(0, 9) == 0) len = $urandom_range(7, 20);
    head = $urandom_range(0, STEP_DEPTH - len);
    hop  = prog_heads.size() > 0 && $urandom_range(0, 4) == 0;
    for (k = 0; k < len; k++) begin
      if (k == 0 && hop) begin
        target = ($urandom_range(0, 3) == 0) ? $urandom_range(0, 16383)
               : prog_heads[$urandom_range(0, prog_heads.size() - 1)];
        void'(add_item(step_cmd(head, 1'($urandom_range(0, 1)), pool_code(), 1'b1, 1'b1,
                                target)));
      end else begin
        kern = 1'($urandom_range(0, 1));
        // goto bit past the head: must read as a plain kern
        void'(add_item(step_cmd(head + k, k == len - 1, pool_code(), kern,
                                kern && $urandom_range(0, 5) == 0,
                                $urandom_range(0, 16383))));
      end
    end
    prog_heads.push_back(head);
    void'(add_item(glyph_cmd(font_code(), pool_code(), 1'b1, head)));
  endtask

  task automatic push_lookup();
    int tries;
    for (tries = 0; tries < 20; tries++)
      if (add_item(pair_cmd(pick_glyph(), pick_glyph()))) return;
    void'(add_item(unused_cmd()));
  endtask

  task automatic fill_random(int n);
    int stop_at;
    int r;
    int start;
    stop_at = issued + n;
    while (issued < stop_at) begin
      r = $urandom_range(0, 99);
      if (r < 6) begin
        add_program();
      end else if (r < 12) begin
        start = (prog_heads.size() > 0 && $urandom_range(0, 1) == 1)
              ? prog_heads[$urandom_range(0, prog_heads.size() - 1)]
              : $urandom_range(0, 1023);
        void'(add_item(glyph_cmd(font_code(), pool_code(), 1'($urandom_range(0, 1)),
                                 start)));
      end else if (r < 17) begin
        void'(add_item(rand_cmd()));
      end else if (r < 20) begin
        void'(add_item(unused_cmd()));
      end else if (r < 22) begin
        void'(add_item(glyph_cmd($urandom_range(GLYPH_DEPTH, 1023), pool_code(),
                                 1'($urandom_range(0, 1)), $urandom_range(0, 1023))));
      end else begin
        push_lookup();
      end
    end
  endtask

  task automatic settle();
    while (in_flight != 0) @(posedge clk);
  endtask

  task automatic set_reg(logic [0:0] idx, logic [8:0] data);
    @(negedge clk);
    cfg_wr_en <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= data;
    if (idx == lkp_pkg::CFG_GLYPH_COUNT) glyph_limit = data;
    else eight_bit = data[0];
    @(negedge clk);
    cfg_wr_en <= 1'b0;
  endtask

  task automatic report_fault(string what);
    faults++;
    if (faults <= FAULT_SHOWN) $display("%s", what);
  endtask

  // source side: after a beat is taken, the next goes out at a falling edge once the drawn gap has run out
  always @(negedge clk) begin
    if (rst) begin
      item_bus.valid <= 1'b0;
    end else if (!item_bus.valid || beat_taken) begin
      beat_taken = 1'b0;
      if (src_gap > 0) begin
        src_gap--;
        item_bus.valid <= 1'b0;
      end else if (backlog.size() > 0) begin
        held = backlog.pop_front();
        item_bus.command             <= held.cmd.command;
        item_bus.table_index         <= held.cmd.table_index;
        item_bus.first_glyph         <= held.cmd.first_glyph;
        item_bus.second_glyph        <= held.cmd.second_glyph;
        item_bus.entry_main_code     <= held.cmd.entry_main_code;
        item_bus.entry_has_program   <= held.cmd.entry_has_program;
        item_bus.entry_program_start <= held.cmd.entry_program_start;
        item_bus.entry_stop          <= held.cmd.entry_stop;
        item_bus.entry_next_code     <= held.cmd.entry_next_code;
        item_bus.entry_is_kern       <= held.cmd.entry_is_kern;
        item_bus.entry_is_goto       <= held.cmd.entry_is_goto;
        item_bus.entry_value         <= held.cmd.entry_value;
        item_bus.valid               <= 1'b1;
        src_gap = draw_gap(src_calm);
        if ($urandom_range(0, 149) == 0) src_calm = !src_calm;
      end else begin
        item_bus.valid <= 1'b0;
      end
    end
  end

  // sink side stalls
  always @(negedge clk) begin
    if ($urandom_range(0, 399) == 0) sink_calm = !sink_calm;
    if (sink_hold == 0 && !sink_calm && $urandom_range(0, 7) == 0)
      sink_hold = draw_gap(1'b0);
    if (sink_hold > 0) begin
      sink_hold--;
      result_bus.ready <= 1'b0;
    end else begin
      result_bus.ready <= 1'b1;
    end
  end

  always @(posedge clk) begin
    reply_t want;
    if (!rst && item_bus.valid && item_bus.ready) begin
      replies_due.push_back(held.want);
      beat_taken = 1'b1;
    end
    if (!rst && result_bus.valid && result_bus.ready) begin
      result_count++;
      if (replies_due.size() == 0) begin
        report_fault($sformatf("result %0d unexpected: status %0d kern %0d glyph %0d",
          result_count, result_bus.status, result_bus.kern_value,
          result_bus.result_glyph));
      end else begin
        want = replies_due.pop_front();
        in_flight--;
        if (result_bus.status !== want.status || result_bus.kern_value !== want.kern ||
            result_bus.result_glyph !== want.glyph)
          report_fault($sformatf(
            "result %0d: expected status %0d kern %0d glyph %0d, got status %0d kern %0d glyph %0d",
            result_count, want.status, $signed(want.kern), want.glyph,
            result_bus.status, result_bus.kern_value, result_bus.result_glyph));
      end
    end
  end

  always @(posedge clk) begin
    if ((item_bus.valid && item_bus.ready) || (result_bus.valid && result_bus.ready))
      stuck_cycles = 0;
    else
      stuck_cycles++;
    if (stuck_cycles >= STUCK_LIMIT) begin
      $display("ligature_kern_program_lookup: mismatch");
      $finish;
    end
  end

  initial begin
    int phase;
    int limits [8];
    rst                          = 1'b1;
    cfg_wr_en                    = 1'b0;
    cfg_index                    = '0;
    cfg_data                     = '0;
    item_bus.valid               = 1'b0;
    item_bus.command             = lkp_pkg::CMD_LOOKUP;
    item_bus.table_index         = '0;
    item_bus.first_glyph         = '0;
    item_bus.second_glyph        = '0;
    item_bus.entry_main_code     = '0;
    item_bus.entry_has_program   = 1'b0;
    item_bus.entry_program_start = '0;
    item_bus.entry_stop          = 1'b0;
    item_bus.entry_next_code     = '0;
    item_bus.entry_is_kern       = 1'b0;
    item_bus.entry_is_goto       = 1'b0;
    item_bus.entry_value         = '0;
    result_bus.ready             = 1'b0;
    glyph_limit                  = '0;
    eight_bit                    = 1'b0;

    // registers at reset: every code is out of range
    void'(add_item(pair_cmd(511, 511)));
    void'(add_item(unused_cmd()));
    void'(add_item(glyph_cmd(1023, 0, 1'b1, 0)));

    repeat (4) @(negedge clk);
    rst <= 1'b0;

    settle();
    set_reg(lkp_pkg::CFG_GLYPH_COUNT, 9'd511);
    set_reg(lkp_pkg::CFG_EIGHT_BIT, {8'($urandom), 1'b1});

    void'(add_item(step_cmd(0, 1'b1, 5, 1'b0, 1'b0, 14'h3fff)));
    void'(add_item(glyph_cmd(0, 5, 1'b1, 0)));
    void'(add_item(step_cmd(1, 1'b0, 3, 1'b1, 1'b0, 14'h2000)));
    void'(add_item(step_cmd(2, 1'b1, 9, 1'b1, 1'b1, 14'h1fff)));
    void'(add_item(glyph_cmd(1, 9, 1'b1, 1)));
    void'(add_item(glyph_cmd(2, 3, 1'b0, 1023)));
    void'(add_item(step_cmd(3, 1'b0, 0, 1'b1, 1'b1, 1)));
    void'(add_item(glyph_cmd(3, 0, 1'b1, 3)));
    void'(add_item(step_cmd(4, 1'b1, 511, 1'b1, 1'b1, 14'h3fff)));
    void'(add_item(glyph_cmd(4, 0, 1'b1, 4)));
    void'(add_item(step_cmd(1022, 1'b0, 100, 1'b0, 1'b0, 0)));
    void'(add_item(step_cmd(1023, 1'b0, 100, 1'b1, 1'b0, 0)));
    void'(add_item(glyph_cmd(5, 6, 1'b1, 1022)));
    void'(add_item(glyph_cmd(511, 511, 1'b0, 0)));
    void'(add_item(pair_cmd(0, 0)));     // ligature
    void'(add_item(pair_cmd(1, 2)));     // most negative kern
    void'(add_item(pair_cmd(1, 1)));     // goto bit mid-program reads as kern
    void'(add_item(pair_cmd(1, 0)));     // stop bit, no match
    void'(add_item(pair_cmd(2, 0)));     // no program
    void'(add_item(pair_cmd(3, 1)));     // leading goto
    void'(add_item(pair_cmd(4, 0)));     // goto past the step table
    void'(add_item(pair_cmd(5, 1)));     // walk runs off the table end
    void'(add_item(pair_cmd(0, 511)));
    void'(add_item(pair_cmd(511, 0)));

    limits = '{511, $urandom_range(16, 510), 1, $urandom_range(48, 510), 0,
               $urandom_range(16, 510), 511, $urandom_range(2, 510)};
    for (phase = 0; phase < 8; phase++) begin
      settle();
      set_reg(lkp_pkg::CFG_GLYPH_COUNT, 9'(limits[phase]));
      set_reg(lkp_pkg::CFG_EIGHT_BIT, {8'($urandom), 1'(phase % 2)});
      fill_random(210);
    end

    settle();
    repeat (100) @(posedge clk);
    if (faults == 0)
      $display("ligature_kern_program_lookup: match");
    else
      $display("ligature_kern_program_lookup: mismatch");
    $finish;
  end

endmodule
